// File: design/cpc_pkg.sv
// Package for the cartesian/polar converter: item structs, fixed-point formats,
// CORDIC gain and the per-stage arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

  // Input item: mode selects the direction, then the cartesian and polar operands.
  typedef struct packed {
    logic               mode;
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
    logic        [15:0] magnitude_in;
    logic signed [15:0] angle_in;
  } in_item_t;

  // Result item: fields of the unused direction read as zero.
  typedef struct packed {
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic        [15:0] magnitude_out;
    logic signed [15:0] angle_out;
  } res_item_t;

  localparam int MAX_STAGES = 24;
  localparam int GUARD      = 12;   // extra fraction bits on coordinates
  localparam int CW         = 32;   // coordinate datapath width
  localparam int ZW         = 28;   // angle accumulator width, 2^-16 degree units
  localparam int KW         = 31;   // gain constant width, signed positive
  localparam int PW         = CW + KW;              // product width
  localparam int RW         = PW - (GUARD + 30);    // width after gain removal

  localparam logic signed [KW-1:0] GAIN_Q30 = 31'sd652032874;
  localparam logic signed [ZW-1:0] DEG180   = 28'sd11796480;

  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int MAG_MAX      = 46341;

  // atan(2^-i) in 2^-16 degree, rounded to nearest
  localparam logic signed [ZW-1:0] STAGE_ANGLE [MAX_STAGES] = '{
    28'sd2949120, 28'sd1740967, 28'sd919879, 28'sd466945,
    28'sd234379,  28'sd117304,  28'sd58666,  28'sd29335,
    28'sd14668,   28'sd7334,    28'sd3667,   28'sd1833,
    28'sd917,     28'sd458,     28'sd229,    28'sd115,
    28'sd57,      28'sd29,      28'sd14,     28'sd7,
    28'sd4,       28'sd2,       28'sd1,      28'sd0
  };

endpackage

`default_nettype wire

// File: design/cartesian_polar_converter.sv
// Cartesian <-> polar converter: fully pipelined CORDIC with gain removal.
// Depends on cpc_pkg (item structs, formats, arctangent table).
// Stages: input register, rotation stages, gain stage, output register; one item per cycle.
// Throughput is one item every cycle: each CORDIC iteration is its own stage.
// busy_o stays low; the receiver cannot stall, so results stream out on done_o.
// Reset (rst_ni low, async) clears all valid bits and drops items in flight.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_polar_converter #(
  parameter int ITERATIONS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  cpc_pkg::in_item_t    in_i,
  output logic                 busy_o,
  output logic                 done_o,
  output cpc_pkg::res_item_t   res_o
);
  import cpc_pkg::*;

  localparam int NSTG = (ITERATIONS < MAX_STAGES) ? ITERATIONS : MAX_STAGES;
  localparam int LAT  = NSTG + 3;

  localparam logic signed [16:0] HALF17  = 17'(HALF_TURN);
  localparam logic signed [16:0] FULL17  = 17'(2 * HALF_TURN);
  localparam logic signed [16:0] QUART17 = 17'(QUARTER_TURN);
  localparam logic signed [ZW-1:0] ZQ_MAX = ZW'(QUARTER_TURN * 512);
  localparam logic signed [ZW-1:0] ANG_HI = ZW'(HALF_TURN);
  localparam logic signed [ZW-1:0] RND_Z  = ZW'(256);
  localparam logic signed [PW-1:0] RND_P  = PW'(64'sd1 << (GUARD + 29));
  localparam logic signed [RW-1:0] MAG_HI = RW'(MAG_MAX);
  localparam logic signed [RW:0]   XY_HI  = (RW+1)'(32767);
  localparam logic signed [RW:0]   XY_LO  = -(RW+1)'(32768);

  logic accept;

  // Pipeline of CORDIC state; index 0 is the prepared item, index NSTG the last rotation.
  logic                 vld_q  [NSTG+1];
  logic                 mode_q [NSTG+1];
  logic                 flip_q [NSTG+1];
  logic                 zero_q [NSTG+1];
  logic signed [CW-1:0] u_q    [NSTG+1];
  logic signed [CW-1:0] v_q    [NSTG+1];
  logic signed [ZW-1:0] z_q    [NSTG+1];

  // Stage 0 next values
  logic signed [CW-1:0] u0_d, v0_d;
  logic signed [ZW-1:0] z0_d;
  logic                 flip0_d, zero0_d;
  logic signed [16:0]   a_wrap, a_red;
  logic signed [CW-1:0] xe, ye, me;

  // Gain stage and output registers
  logic                 mv_q, mm_q, mf_q, mz_q;
  logic signed [PW-1:0] pu_q, pv_q;
  logic signed [15:0]   ang_q;
  logic signed [15:0]   ang_d;
  logic signed [ZW-1:0] zr;
  logic signed [PW-1:0] pu_r, pv_r;
  logic signed [RW-1:0] ru, rv;
  logic signed [RW:0]   xs_e, ys_e;
  res_item_t            res_d;
  res_item_t            res_q;
  logic                 done_q;

  // The pipeline never stalls, so an item is taken on every start.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Prepare: fold the input into the half plane / quarter turn the CORDIC covers.
  always_comb begin
    xe      = CW'(in_i.x_in);
    ye      = CW'(in_i.y_in);
    me      = CW'(in_i.magnitude_in);
    a_wrap  = 17'(in_i.angle_in);
    a_red   = '0;
    flip0_d = 1'b0;
    zero0_d = 1'b0;
    u0_d    = '0;
    v0_d    = '0;
    z0_d    = '0;
    if (!in_i.mode) begin
      zero0_d = (in_i.x_in == 16'sd0) && (in_i.y_in == 16'sd0);
      u0_d    = ye <<< GUARD;
      v0_d    = xe <<< GUARD;
      if (in_i.y_in < 16'sd0) begin
        // lower half plane: negate and start from a half turn
        z0_d = (in_i.x_in >= 16'sd0) ? DEG180 : -DEG180;
        u0_d = -(ye <<< GUARD);
        v0_d = -(xe <<< GUARD);
      end
    end else begin
      if (a_wrap > HALF17) begin
        a_wrap = a_wrap - FULL17;
      end else if (a_wrap < -HALF17) begin
        a_wrap = a_wrap + FULL17;
      end
      a_red = a_wrap;
      if (a_wrap > QUART17) begin
        a_red   = a_wrap - HALF17;
        flip0_d = 1'b1;
      end else if (a_wrap < -QUART17) begin
        a_red   = a_wrap + HALF17;
        flip0_d = 1'b1;
      end
      z0_d = ZW'(a_red) <<< 9;
      u0_d = me <<< GUARD;
      v0_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q[0] <= in_i.mode;
      flip_q[0] <= flip0_d;
      zero_q[0] <= zero0_d;
      u_q[0]    <= u0_d;
      v_q[0]    <= v0_d;
      z_q[0]    <= z0_d;
    end
  end

  // One micro-rotation per stage. Vectoring drives v to zero, rotation drives z to zero;
  // both share the datapath with the direction decision swapped.
  for (genvar k = 1; k <= NSTG; k++) begin : g_stage
    logic signed [CW-1:0] du, dv;
    logic                 pos;

    assign du  = v_q[k-1] >>> (k - 1);
    assign dv  = u_q[k-1] >>> (k - 1);
    assign pos = mode_q[k-1] ? z_q[k-1][ZW-1] : !v_q[k-1][CW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      mode_q[k] <= mode_q[k-1];
      flip_q[k] <= flip_q[k-1];
      zero_q[k] <= zero_q[k-1];
      if (pos) begin
        u_q[k] <= u_q[k-1] + du;
        v_q[k] <= v_q[k-1] - dv;
        z_q[k] <= z_q[k-1] + STAGE_ANGLE[k-1];
      end else begin
        u_q[k] <= u_q[k-1] - du;
        v_q[k] <= v_q[k-1] + dv;
        z_q[k] <= z_q[k-1] - STAGE_ANGLE[k-1];
      end
    end
  end

  // Gain stage: multiply out the CORDIC gain, round the angle to 1/128 degree and clamp it.
  always_comb begin
    zr = (z_q[NSTG] + RND_Z) >>> 9;
    if (zr > ANG_HI) begin
      ang_d = 16'(ANG_HI);
    end else if (zr < -ANG_HI) begin
      ang_d = 16'(-ANG_HI);
    end else begin
      ang_d = zr[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= vld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    mm_q  <= mode_q[NSTG];
    mf_q  <= flip_q[NSTG];
    mz_q  <= zero_q[NSTG];
    pu_q  <= u_q[NSTG] * GAIN_Q30;
    pv_q  <= v_q[NSTG] * GAIN_Q30;
    ang_q <= ang_d;
  end

  // Output stage: round half up, drop guard bits, apply the flip, clamp.
  always_comb begin
    pu_r  = (pu_q + RND_P) >>> (GUARD + 30);
    pv_r  = (pv_q + RND_P) >>> (GUARD + 30);
    ru    = pu_r[RW-1:0];
    rv    = pv_r[RW-1:0];
    ys_e  = mf_q ? -(RW+1)'(ru) : (RW+1)'(ru);
    xs_e  = mf_q ? -(RW+1)'(rv) : (RW+1)'(rv);
    res_d = '0;
    if (!mm_q) begin
      if (!mz_q) begin
        if (ru < 0) begin
          res_d.magnitude_out = '0;
        end else if (ru > MAG_HI) begin
          res_d.magnitude_out = 16'(MAG_MAX);
        end else begin
          res_d.magnitude_out = ru[15:0];
        end
        res_d.angle_out = ang_q;
      end
    end else begin
      if (xs_e > XY_HI) begin
        res_d.x_out = 16'sh7fff;
      end else if (xs_e < XY_LO) begin
        res_d.x_out = 16'sh8000;
      end else begin
        res_d.x_out = xs_e[15:0];
      end
      if (ys_e > XY_HI) begin
        res_d.y_out = 16'sh7fff;
      end else if (ys_e < XY_LO) begin
        res_d.y_out = 16'sh8000;
      end else begin
        res_d.y_out = ys_e[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // A result strobe must trace back to an accepted item that has run the whole pipeline.
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result strobe without matching accepted item");

  // Only one direction's fields may carry data in a result.
  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((res_o.x_out == 16'sd0 && res_o.y_out == 16'sd0) ||
                (res_o.magnitude_out == 16'd0 && res_o.angle_out == 16'sd0)))
    else $error("result mixes polar and cartesian fields");

  // Polar results stay within their clamp limits.
  a_polar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.magnitude_out <= 16'(MAG_MAX) &&
                res_o.angle_out <= 16'(HALF_TURN) && res_o.angle_out >= -16'(HALF_TURN)))
    else $error("polar result outside clamp limits");

  // Rotation items enter the CORDIC within a quarter turn.
  a_quarter_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && mode_q[0]) |-> (z_q[0] <= ZQ_MAX && z_q[0] >= -ZQ_MAX))
    else $error("rotation angle not reduced to a quarter turn");

endmodule

`default_nettype wire

// File: bench/tb_cartesian_polar_converter.sv
// Self-checking testbench for cartesian_polar_converter: directed table, then random
// items in bursts, checked against hand-written rows or a CORDIC predictor in this file.
// Depends on cpc_pkg (item structs) and the converter RTL.
`timescale 1ns / 1ps

module tb_cartesian_polar_converter;
  import cpc_pkg::*;

  // Direction codes carried in the mode field.
  localparam logic MODE_TO_POLAR = 1'b0;
  localparam logic MODE_TO_CART  = 1'b1;

  localparam int     STAGES       = 16;
  localparam int     STAGE_LIMIT  = 24;
  localparam int     PIPE_DEPTH   = STAGES + 3;
  localparam int     RANDOM_ITEMS = 1100;
  localparam int     DRAIN_LIMIT  = 400;
  localparam longint COORD_GUARD  = 12;
  localparam longint GAIN_Q30     = 64'sd652032874;
  localparam longint GAIN_ROUND   = 64'sd1 << 41;
  localparam longint DEG180_Z     = 64'sd11796480;
  localparam longint HALF_TURN    = 23040;
  localparam longint QUARTER_TURN = 11520;
  localparam longint MAG_LIMIT    = 46341;
  localparam int     REPORT_LIMIT = 10;

  // Arctangent of 2^-i in 2^-16 degree, one entry per CORDIC rotation.
  localparam longint ATAN_STEP [STAGE_LIMIT] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    in_item_t  stim;
    logic      typed;   // want holds the result written out by hand
    res_item_t want;
  } dir_row_t;

  typedef struct {
    in_item_t  stim;
    res_item_t want;
  } pending_t;

  // Directed items: extremes of every field, both half planes, the origin,
  // angle wrap beyond half a turn, the quarter-turn flip and output saturation.
  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // origin gives all zero, polar operands present but ignored
    '{'{MODE_TO_POLAR, 16'sd0, 16'sd0, 16'hFFFF, -16'sd1}, 1'b1, '0},
    '{'{MODE_TO_POLAR, 16'sd32767, 16'sd32767, 16'd0, 16'sd0}, 1'b0, '0},
    '{'{MODE_TO_POLAR, 16'sh8000, 16'sh8000, 16'd0, 16'sd0}, 1'b0, '0},
    '{'{MODE_TO_POLAR, 16'sd0, 16'sd32767, 16'd0, 16'sd0}, 1'b0, '0},
    '{'{MODE_TO_POLAR, 16'sd32767, 16'sd0, 16'd0, 16'sd0}, 1'b0, '0},
    '{'{MODE_TO_POLAR, 16'sh8000, 16'sd0, 16'd0, 16'sd0}, 1'b0, '0},
    // lower half plane: base angle +180 for x >= 0, -180 otherwise
    '{'{MODE_TO_POLAR, 16'sd0, 16'sh8000, 16'd0, 16'sd0}, 1'b0, '0},
    '{'{MODE_TO_POLAR, -16'sd1, 16'sh8000, 16'd0, 16'sd0}, 1'b0, '0},
    '{'{MODE_TO_POLAR, 16'sd1, -16'sd1, 16'd0, 16'sd0}, 1'b0, '0},
    '{'{MODE_TO_POLAR, 16'sd0, -16'sd1, 16'd0, 16'sd0}, 1'b0, '0},
    '{'{MODE_TO_POLAR, 16'sd1, 16'sd0, 16'd0, 16'sd0}, 1'b0, '0},
    // zero magnitude gives all zero whatever the angle
    '{'{MODE_TO_CART, 16'sd32767, 16'sh8000, 16'd0, 16'sd12345}, 1'b1, '0},
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'd0, 16'sh8000}, 1'b1, '0},
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'd46341, 16'sd0}, 1'b0, '0},
    // oversized magnitude saturates y, and x too at 45 degrees
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'hFFFF, 16'sd5760}, 1'b0, '0},
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'hFFFF, 16'sd0}, 1'b0, '0},
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'd16, 16'sd23040}, 1'b0, '0},
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'd16, -16'sd23040}, 1'b0, '0},
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'd4000, 16'sd23041}, 1'b0, '0},
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'd4000, -16'sd23041}, 1'b0, '0},
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'd4000, 16'sd32767}, 1'b0, '0},
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'd4000, 16'sh8000}, 1'b0, '0},
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'd4000, 16'sd11520}, 1'b0, '0},
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'd4000, 16'sd11521}, 1'b0, '0},
    '{'{MODE_TO_CART, 16'sd0, 16'sd0, 16'd4000, -16'sd11521}, 1'b0, '0}
  };

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  in_item_t  in_i;
  logic      busy_o;
  logic      done_o;
  res_item_t res_o;

  pending_t pending_results [$];
  int       mismatches = 0;

  cartesian_polar_converter #(
    .ITERATIONS(STAGES)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .in_i  (in_i),
    .busy_o(busy_o),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[cartesian_polar_converter] ERROR");
    $finish;
  end

  function automatic longint clamp_to(input longint val, input longint lo, input longint hi);
    return (val < lo) ? lo : ((val > hi) ? hi : val);
  endfunction

  // Strip the CORDIC gain and the guard bits, rounding half up.
  function automatic longint remove_gain(input longint val);
    return (val * GAIN_Q30 + GAIN_ROUND) >>> (30 + COORD_GUARD);
  endfunction

  // Work out the result item the converter must return for one input item.
  function automatic res_item_t convert_point(input in_item_t it);
    longint    u, v, z, du, dv, ang;
    longint    xo, yo, mo, ao;
    logic      flip;
    int        n;
    res_item_t r;
    n  = (STAGES < STAGE_LIMIT) ? STAGES : STAGE_LIMIT;
    xo = 0; yo = 0; mo = 0; ao = 0;
    if (it.mode == MODE_TO_POLAR) begin
      if (it.x_in != 0 || it.y_in != 0) begin
        u = longint'($signed(it.y_in)) <<< COORD_GUARD;
        v = longint'($signed(it.x_in)) <<< COORD_GUARD;
        z = 0;
        // Fold the lower half plane onto the upper one, base angle +-180.
        if (u < 0) begin
          z = (v >= 0) ? DEG180_Z : -DEG180_Z;
          u = -u;
          v = -v;
        end
        for (int i = 0; i < n; i++) begin
          du = v >>> i;
          dv = u >>> i;
          if (v >= 0) begin
            u += du; v -= dv; z += ATAN_STEP[i];
          end else begin
            u -= du; v += dv; z -= ATAN_STEP[i];
          end
        end
        mo = clamp_to(remove_gain(u), 0, MAG_LIMIT);
        ao = clamp_to((z + 256) >>> 9, -HALF_TURN, HALF_TURN);
      end
    end else begin
      ang  = longint'($signed(it.angle_in));
      flip = 1'b0;
      if (ang > HALF_TURN) ang -= 2 * HALF_TURN;
      else if (ang < -HALF_TURN) ang += 2 * HALF_TURN;
      // Beyond a quarter turn: rotate by 180 and negate the result.
      if (ang > QUARTER_TURN) begin
        ang -= HALF_TURN; flip = 1'b1;
      end else if (ang < -QUARTER_TURN) begin
        ang += HALF_TURN; flip = 1'b1;
      end
      z = ang * 512;
      u = longint'(it.magnitude_in) <<< COORD_GUARD;
      v = 0;
      for (int i = 0; i < n; i++) begin
        du = v >>> i;
        dv = u >>> i;
        if (z >= 0) begin
          u -= du; v += dv; z -= ATAN_STEP[i];
        end else begin
          u += du; v -= dv; z += ATAN_STEP[i];
        end
      end
      yo = remove_gain(u);
      xo = remove_gain(v);
      if (flip) begin
        yo = -yo;
        xo = -xo;
      end
      xo = clamp_to(xo, -32768, 32767);
      yo = clamp_to(yo, -32768, 32767);
    end
    r.x_out         = xo[15:0];
    r.y_out         = yo[15:0];
    r.magnitude_out = mo[15:0];
    r.angle_out     = ao[15:0];
    return r;
  endfunction

  // Pick a coordinate: full range, near zero, or one of the edges.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 128) - 64);
      1: return ($urandom_range(0, 1) != 0) ? 16'h7FFF - 16'($urandom_range(0, 3))
                                            : 16'h8000 + 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t pick_item();
    in_item_t it;
    it.mode         = logic'($urandom_range(0, 1));
    it.x_in         = pick_coord();
    it.y_in         = pick_coord();
    case ($urandom_range(0, 4))
      0:       it.magnitude_in = 16'($urandom);
      1:       it.magnitude_in = 16'($urandom_range(0, 64));
      default: it.magnitude_in = 16'($urandom_range(0, MAG_LIMIT));
    endcase
    case ($urandom_range(0, 4))
      0:       it.angle_in = 16'($urandom);
      1:       it.angle_in = 16'($urandom_range(0, 64) - 32 + 11520 * $urandom_range(0, 4)
                                 - 23040);
      default: it.angle_in = 16'($urandom_range(0, 2 * HALF_TURN) - HALF_TURN);
    endcase
    return it;
  endfunction

  // Present one item and hold it until the handshake; log what must come back.
  task automatic drive_item(input in_item_t it, input logic typed, input res_item_t want);
    pending_t entry;
    start_i <= 1'b1;
    in_i    <= it;
    do @(posedge clk_i); while (busy_o);
    entry.stim = it;
    entry.want = typed ? want : convert_point(it);
    pending_results.push_back(entry);
  endtask

  // Drop start for a number of cycles; scramble the operands meanwhile.
  task automatic hold_idle(input int cycles);
    start_i <= 1'b0;
    in_i    <= pick_item();
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop start and advance until every logged item has come back, with a bound.
  task automatic wait_drained();
    int waited;
    waited  = 0;
    start_i <= 1'b0;
    while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Compare every strobed result with the oldest logged item, field by field.
  always @(posedge clk_i) begin
    pending_t  head;
    res_item_t got;
    logic      bad;
    if (rst_ni && done_o) begin
      got = res_o;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: x=%0d y=%0d mag=%0d ang=%0d",
                   got.x_out, got.y_out, got.magnitude_out, got.angle_out);
      end else begin
        head = pending_results.pop_front();
        bad  = (got.x_out !== head.want.x_out) || (got.y_out !== head.want.y_out) ||
               (got.magnitude_out !== head.want.magnitude_out) ||
               (got.angle_out !== head.want.angle_out);
        if (bad) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch mode=%0d x_in=%0d y_in=%0d mag_in=%0d ang_in=%0d: %s",
                     head.stim.mode, head.stim.x_in, head.stim.y_in,
                     head.stim.magnitude_in, head.stim.angle_in,
                     $sformatf("exp x=%0d y=%0d mag=%0d ang=%0d got x=%0d y=%0d mag=%0d ang=%0d",
                               head.want.x_out, head.want.y_out, head.want.magnitude_out,
                               head.want.angle_out, got.x_out, got.y_out,
                               got.magnitude_out, got.angle_out));
        end
      end
    end
  end

  initial begin
    int  sent;
    int  burst;
    logic paused;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    in_i    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table back to back.
    for (int r = 0; r < DIR_ROWS; r++)
      drive_item(DIR_TABLE[r].stim, DIR_TABLE[r].typed, DIR_TABLE[r].want);
    wait_drained();

    // Random items in bursts; some gaps are zero so long streams run unbroken.
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 48);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        drive_item(pick_item(), 1'b0, '0);
        sent++;
      end
      // Halfway through, hold off until the pipeline is empty.
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end else if ($urandom_range(0, 3) != 0) begin
        hold_idle($urandom_range(1, 8));
      end
    end

    wait_drained();
    start_i <= 1'b0;
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    if (pending_results.size() > 0) begin
      mismatches += pending_results.size();
      $display("%0d items never returned a result", pending_results.size());
    end
    if (mismatches == 0) begin
      $display("[cartesian_polar_converter] OK");
    end else begin
      $display("[cartesian_polar_converter] ERROR");
    end
    $finish;
  end

endmodule

// File: cartesian_polar_converter.f
design/cpc_pkg.sv
design/cartesian_polar_converter.sv
bench/tb_cartesian_polar_converter.sv
